FILE: design/grouped_leave_one_out_max_unit_defines.svh
// Assertion macros shared by the RTL of the leave-one-out max unit.
`ifndef GROUPED_LEAVE_ONE_OUT_MAX_UNIT_DEFINES_SVH
`define GROUPED_LEAVE_ONE_OUT_MAX_UNIT_DEFINES_SVH

`ifndef SYNTH
// checked only out of reset
`define GLOM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define GLOM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GLOM_ASSERT(lbl, clk, rst_n, prop, msg)
`define GLOM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: design/glom_pkg.sv
`default_nettype none

package glom_pkg;

    localparam int GID_W         = 16;
    localparam int DATA_W        = 32;
    localparam int MAX_GROUP_DEF = 32;

    // Per-group figures handed from the tracker to the emitter at flush time.
    typedef struct packed {
        logic [GID_W-1:0]         gid;
        logic signed [DATA_W-1:0] top;
        logic signed [DATA_W-1:0] second;
        logic                     ovf;
    } grp_stat_t;

endpackage

`default_nettype wire

FILE: design/glom_buf.sv
`default_nettype none

module glom_buf #(
    parameter int DEPTH = glom_pkg::MAX_GROUP_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [AW-1:0]                    wr_addr,
    input  logic signed [glom_pkg::DATA_W-1:0] wr_data,
    input  logic                             rd_en,
    input  logic [AW-1:0]                    rd_addr,
    output logic signed [glom_pkg::DATA_W-1:0] rd_data
);
    import glom_pkg::*;

    logic signed [DATA_W-1:0] value_mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            value_mem[wr_addr] <= wr_data;
        end
    end

    // hold read data until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= value_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: design/glom_track.sv
`default_nettype none

module glom_track #(
    parameter int MAX_GROUP = glom_pkg::MAX_GROUP_DEF,
    parameter int IDX_W     = $clog2(MAX_GROUP),
    parameter int CNT_W     = $clog2(MAX_GROUP + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               take_en,
    input  logic [glom_pkg::GID_W-1:0]         take_gid,
    input  logic signed [glom_pkg::DATA_W-1:0] take_val,
    input  logic                               clear,
    output glom_pkg::grp_stat_t                stat,
    output logic [CNT_W-1:0]                   fill,
    output logic                               group_open,
    output logic                               wr_en,
    output logic [IDX_W-1:0]                   wr_addr,
    output logic signed [glom_pkg::DATA_W-1:0] wr_data
);
    import glom_pkg::*;

    logic                     group_open_reg, group_open_next;
    logic [GID_W-1:0]         open_group_reg, open_group_next;
    logic signed [DATA_W-1:0] top_reg, top_next;
    logic signed [DATA_W-1:0] second_reg, second_next;
    logic [CNT_W-1:0]         fill_reg, fill_next;
    logic                     ovf_reg, ovf_next;

    logic [CNT_W-1:0]         base_fill;
    logic signed [DATA_W-1:0] base_top;
    logic signed [DATA_W-1:0] base_second;
    logic                     base_ovf;

    always_comb begin
        // a closed group reads as a fresh one
        base_fill   = group_open_reg ? fill_reg   : '0;
        base_top    = group_open_reg ? top_reg    : '0;
        base_second = group_open_reg ? second_reg : '0;
        base_ovf    = group_open_reg ? ovf_reg    : 1'b0;

        group_open_next = group_open_reg;
        open_group_next = open_group_reg;
        top_next        = top_reg;
        second_next     = second_reg;
        fill_next       = fill_reg;
        ovf_next        = ovf_reg;
        wr_en           = 1'b0;
        wr_addr         = IDX_W'(base_fill);

        if (clear) begin
            group_open_next = 1'b0;
            top_next        = '0;
            second_next     = '0;
            fill_next       = '0;
            ovf_next        = 1'b0;
        end else if (take_en) begin
            group_open_next = 1'b1;
            open_group_next = take_gid;
            top_next        = base_top;
            second_next     = base_second;
            fill_next       = base_fill;
            ovf_next        = base_ovf;
            if (base_fill >= CNT_W'(MAX_GROUP)) begin
                // drop the item, mark the group
                ovf_next = 1'b1;
            end else begin
                wr_en     = 1'b1;
                fill_next = base_fill + CNT_W'(1);
                if (base_fill == '0) begin
                    top_next    = take_val;
                    second_next = '0;
                end else if (base_fill == CNT_W'(1)) begin
                    if (take_val >= base_top) begin
                        second_next = base_top;
                        top_next    = take_val;
                    end else begin
                        second_next = take_val;
                    end
                end else if (take_val >= base_top) begin
                    second_next = base_top;
                    top_next    = take_val;
                end else if (take_val >= base_second) begin
                    second_next = take_val;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_open_reg <= 1'b0;
            open_group_reg <= '0;
            top_reg        <= '0;
            second_reg     <= '0;
            fill_reg       <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            group_open_reg <= group_open_next;
            open_group_reg <= open_group_next;
            top_reg        <= top_next;
            second_reg     <= second_next;
            fill_reg       <= fill_next;
            ovf_reg        <= ovf_next;
        end
    end

    assign stat.gid    = open_group_reg;
    assign stat.top    = top_reg;
    assign stat.second = second_reg;
    assign stat.ovf    = ovf_reg;
    assign fill        = fill_reg;
    assign group_open  = group_open_reg;
    assign wr_data     = take_val;

endmodule

`default_nettype wire

FILE: design/glom_emit.sv
`default_nettype none

module glom_emit #(
    parameter int MAX_GROUP = glom_pkg::MAX_GROUP_DEF,
    parameter int IDX_W     = $clog2(MAX_GROUP),
    parameter int CNT_W     = $clog2(MAX_GROUP + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  glom_pkg::grp_stat_t                stat,
    input  logic [CNT_W-1:0]                   fill,
    output logic                               rd_en,
    output logic [IDX_W-1:0]                   rd_addr,
    input  logic signed [glom_pkg::DATA_W-1:0] rd_data,
    output logic                               issuing,
    output logic                               idle,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [glom_pkg::GID_W-1:0]         m_out_group,
    output logic signed [glom_pkg::DATA_W-1:0] m_item_value,
    output logic signed [glom_pkg::DATA_W-1:0] m_other_max,
    output logic                               m_group_last,
    output logic                               m_lone_item,
    output logic                               m_overflowed
);
    import glom_pkg::*;

    grp_stat_t                snap_reg;
    logic [CNT_W-1:0]         snap_fill_reg;
    logic                     issuing_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic                     rd_vld_reg;
    logic [IDX_W-1:0]         s1_idx_reg;

    logic                     m_valid_reg;
    logic [GID_W-1:0]         out_group_reg;
    logic signed [DATA_W-1:0] item_value_reg;
    logic signed [DATA_W-1:0] other_max_reg;
    logic                     group_last_reg;
    logic                     lone_item_reg;
    logic                     overflowed_reg;

    logic [IDX_W-1:0]         last_idx;
    logic                     s1_adv;
    logic                     lone;

    assign last_idx = IDX_W'(snap_fill_reg - CNT_W'(1));
    assign lone     = (snap_fill_reg == CNT_W'(1));
    assign s1_adv   = rd_vld_reg && (!m_valid_reg || m_ready);
    assign rd_en    = issuing_reg && (!rd_vld_reg || s1_adv);
    assign rd_addr  = rd_idx_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            snap_reg      <= stat;
            snap_fill_reg <= fill;
        end
        if (rd_en) begin
            s1_idx_reg <= rd_idx_reg;
        end
        if (s1_adv) begin
            out_group_reg  <= snap_reg.gid;
            item_value_reg <= rd_data;
            other_max_reg  <= lone ? '0 :
                              ((rd_data == snap_reg.top) ? snap_reg.second : snap_reg.top);
            group_last_reg <= (s1_idx_reg == last_idx);
            lone_item_reg  <= lone;
            overflowed_reg <= snap_reg.ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issuing_reg <= 1'b0;
            rd_idx_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (start) begin
                issuing_reg <= 1'b1;
                rd_idx_reg  <= '0;
            end else if (rd_en) begin
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                if (rd_idx_reg == last_idx) begin
                    issuing_reg <= 1'b0;
                end
            end

            if (rd_en) begin
                rd_vld_reg <= 1'b1;
            end else if (s1_adv) begin
                rd_vld_reg <= 1'b0;
            end

            if (s1_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign issuing      = issuing_reg;
    assign idle         = !issuing_reg && !rd_vld_reg;
    assign m_valid      = m_valid_reg;
    assign m_out_group  = out_group_reg;
    assign m_item_value = item_value_reg;
    assign m_other_max  = other_max_reg;
    assign m_group_last = group_last_reg;
    assign m_lone_item  = lone_item_reg;
    assign m_overflowed = overflowed_reg;

endmodule

`default_nettype wire

FILE: design/grouped_leave_one_out_max_unit.sv
// Leave-one-out maximum over contiguous groups.
// Input channel s_*: one (group id, value, end of stream) item per handshake.
// Output channel m_*: one result per stored item of a closed group, in arrival
// order, carrying the largest value among the other items of that group.
// A group closes when an item with a new group id arrives (the old group is
// emitted first, then the item opens the new group) or when an item carries
// end of stream (that item joins and the group is emitted at once).
// Throughput: one item per cycle while a group collects. A flush reads the
// value memory one entry per cycle while the output moves, with s_ready low
// until every read has been issued; the first result passes through the flush
// start, the memory read and the output register; results then follow one per
// cycle while m_ready stays high. A group change adds the ST_TAKE reload.
// Items beyond MAX_GROUP are dropped and the group's results flag overflow.
// A stall on m_ready holds the output register and then the read stage;
// reading, and with it input acceptance, resumes as soon as it moves again.
// Reset (aresetn low, synchronous) closes any open group and empties the
// result pipeline; the value memory needs no clearing.
`default_nettype none
`include "grouped_leave_one_out_max_unit_defines.svh"

module grouped_leave_one_out_max_unit #(
    parameter int MAX_GROUP = glom_pkg::MAX_GROUP_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [glom_pkg::GID_W-1:0]         s_group_id,
    input  logic signed [glom_pkg::DATA_W-1:0] s_sample_value,
    input  logic                               s_end_of_stream,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [glom_pkg::GID_W-1:0]         m_out_group,
    output logic signed [glom_pkg::DATA_W-1:0] m_item_value,
    output logic signed [glom_pkg::DATA_W-1:0] m_other_max,
    output logic                               m_group_last,
    output logic                               m_lone_item,
    output logic                               m_overflowed
);
    import glom_pkg::*;

    localparam int IDX_W = $clog2(MAX_GROUP);
    localparam int CNT_W = $clog2(MAX_GROUP + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_TAKE  = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic                     pend_vld_reg, pend_vld_next;
    logic [GID_W-1:0]         pend_gid_reg;
    logic signed [DATA_W-1:0] pend_val_reg;
    logic                     pend_eos_reg;
    logic                     pend_load;

    logic                     take_en;
    logic [GID_W-1:0]         take_gid;
    logic signed [DATA_W-1:0] take_val;
    logic                     flush_go;

    grp_stat_t                stat;
    logic [CNT_W-1:0]         fill;
    logic                     group_open;
    logic                     mem_wr_en;
    logic [IDX_W-1:0]         mem_wr_addr;
    logic signed [DATA_W-1:0] mem_wr_data;
    logic                     mem_rd_en;
    logic [IDX_W-1:0]         mem_rd_addr;
    logic signed [DATA_W-1:0] mem_rd_data;
    logic                     emit_issuing;
    logic                     emit_idle;

    logic                     s_accept;
    logic                     group_change;

    assign s_ready      = (state_reg == ST_IDLE) && !emit_issuing;
    assign s_accept     = s_valid && s_ready;
    assign group_change = group_open && (s_group_id != stat.gid);

    always_comb begin
        state_next    = state_reg;
        pend_vld_next = pend_vld_reg;
        pend_load     = 1'b0;
        take_en       = 1'b0;
        take_gid      = s_group_id;
        take_val      = s_sample_value;
        flush_go      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (group_change) begin
                        // hold the item until the old group is flushed
                        pend_load     = 1'b1;
                        pend_vld_next = 1'b1;
                        state_next    = ST_FLUSH;
                    end else begin
                        take_en = 1'b1;
                        if (s_end_of_stream) begin
                            pend_vld_next = 1'b0;
                            state_next    = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (emit_idle) begin
                    flush_go   = 1'b1;
                    state_next = pend_vld_reg ? ST_TAKE : ST_IDLE;
                end
            end
            ST_TAKE: begin
                take_gid = pend_gid_reg;
                take_val = pend_val_reg;
                // wait until every read of the old group has been issued
                if (!emit_issuing) begin
                    take_en       = 1'b1;
                    pend_vld_next = 1'b0;
                    state_next    = pend_eos_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_vld_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_load) begin
            pend_gid_reg <= s_group_id;
            pend_val_reg <= s_sample_value;
            pend_eos_reg <= s_end_of_stream;
        end
    end

    glom_track #(
        .MAX_GROUP (MAX_GROUP),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .take_en    (take_en),
        .take_gid   (take_gid),
        .take_val   (take_val),
        .clear      (flush_go),
        .stat       (stat),
        .fill       (fill),
        .group_open (group_open),
        .wr_en      (mem_wr_en),
        .wr_addr    (mem_wr_addr),
        .wr_data    (mem_wr_data)
    );

    glom_buf #(
        .DEPTH (MAX_GROUP),
        .AW    (IDX_W)
    ) u_buf (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    glom_emit #(
        .MAX_GROUP (MAX_GROUP),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_emit (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (flush_go),
        .stat         (stat),
        .fill         (fill),
        .rd_en        (mem_rd_en),
        .rd_addr      (mem_rd_addr),
        .rd_data      (mem_rd_data),
        .issuing      (emit_issuing),
        .idle         (emit_idle),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_group  (m_out_group),
        .m_item_value (m_item_value),
        .m_other_max  (m_other_max),
        .m_group_last (m_group_last),
        .m_lone_item  (m_lone_item),
        .m_overflowed (m_overflowed)
    );

    `GLOM_ASSERT(a_no_wr_while_rd, aclk, aresetn, !(mem_wr_en && mem_rd_en), "buffer written during flush read")
    `GLOM_ASSERT(a_lone_is_last, aclk, aresetn, (m_valid && m_lone_item) |-> m_group_last, "lone item result not marked last")
    `GLOM_ASSERT(a_fill_bound, aclk, aresetn, fill <= CNT_W'(MAX_GROUP), "fill count beyond capacity")
    `GLOM_ASSERT(a_open_nonempty, aclk, aresetn, group_open |-> (fill != '0), "open group holds no item")

endmodule

`default_nettype wire
